// ===== src/assert_macros.svh =====
// Assertion macros shared by the checker module of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// ===== src/wtirq_pkg.sv =====
// Shared types, mode codes and constants of the wavetable RAM port and interrupt counter.
package wtirq_pkg;

	localparam int RAM_BYTES = 128;
	localparam int PTR_W     = $clog2(RAM_BYTES);

	// Transfer modes.
	localparam logic [2:0] MODE_ADDR_WR   = 3'd0;
	localparam logic [2:0] MODE_DATA_WR   = 3'd1;
	localparam logic [2:0] MODE_DATA_RD   = 3'd2;
	localparam logic [2:0] MODE_CNT_LO_WR = 3'd3;
	localparam logic [2:0] MODE_CNT_HI_WR = 3'd4;
	localparam logic [2:0] MODE_CNT_LO_RD = 3'd5;
	localparam logic [2:0] MODE_CNT_HI_RD = 3'd6;
	localparam logic [2:0] MODE_TICK      = 3'd7;

	// RAM byte that holds the channel count, and the counter's terminal value.
	localparam logic [PTR_W-1:0] CHAN_REG = PTR_W'(RAM_BYTES - 1);
	localparam logic [15:0]      CNT_TOP  = 16'hFFFF;

	typedef struct packed {
		logic [2:0] mode;
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] read_value;
		logic       irq_line;
		logic [3:0] active_channels;
	} out_item_t;

endpackage

// ===== src/wtirq_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
module wtirq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== src/wavetable_ram_port_and_irq_counter_core.sv =====
// A result strobes on done in the cycle after its transfer is taken.
// Busy is high while the result is shown, so no new transfer is taken then, because
// a data read needs the registered read of the sound RAM.
// Reset: asynchronous, clears pointer, counter and interrupt, sets auto-increment, and
// marks every RAM byte invalid at once so that it reads as zero until written.
module wavetable_ram_port_and_irq_counter_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  wtirq_pkg::in_item_t  item,
	output logic                 done,
	output wtirq_pkg::out_item_t result
);

	logic                          accept;
	logic [wtirq_pkg::PTR_W-1:0]   ptr_q;
	logic                          inc_q;
	logic [15:0]                   cnt_q;
	logic                          irq_q;
	logic [2:0]                    chan_q;
	logic [wtirq_pkg::RAM_BYTES-1:0] valid_q;
	logic                          done_q;
	logic [2:0]                    mode_s1;
	logic                          rd_valid_s1;
	logic                          ram_wr;
	logic                          ram_rd;
	logic [7:0]                    ram_rdata;
	logic [15:0]                   cnt_inc;

	assign accept  = start & ~busy;
	assign busy    = done_q;
	assign done    = done_q;
	assign ram_wr  = accept && (item.mode == wtirq_pkg::MODE_DATA_WR);
	assign ram_rd  = accept && (item.mode == wtirq_pkg::MODE_DATA_RD);
	assign cnt_inc = cnt_q + 16'd1;

	// Sound RAM; the pointer addresses both ports.
	wtirq_ram #(
		.WIDTH(8),
		.DEPTH(wtirq_pkg::RAM_BYTES)
	) u_sound_ram (
		.clk    (clk),
		.wr_en  (ram_wr),
		.wr_addr(ptr_q),
		.wr_data(item.data_byte),
		.rd_en  (ram_rd),
		.rd_addr(ptr_q),
		.rd_data(ram_rdata)
	);

	// Result stage: holds the transfer's mode and whether the byte read was ever written.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1     <= item.mode;
			rd_valid_s1 <= valid_q[ptr_q];
		end
	end

	// Pointer, increment flag, counter, interrupt, byte valid bits and the channel-count shadow of the last RAM byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q   <= '0;
			inc_q   <= 1'b1;
			cnt_q   <= '0;
			irq_q   <= 1'b0;
			chan_q  <= '0;
			valid_q <= '0;
		end else if (accept) begin
			unique case (item.mode)
				wtirq_pkg::MODE_ADDR_WR: begin
					ptr_q <= item.data_byte[wtirq_pkg::PTR_W-1:0];
					inc_q <= item.data_byte[7];
				end
				wtirq_pkg::MODE_DATA_WR: begin
					valid_q[ptr_q] <= 1'b1;
					if (ptr_q == wtirq_pkg::CHAN_REG) begin
						chan_q <= item.data_byte[6:4];
					end
					ptr_q <= ptr_q + wtirq_pkg::PTR_W'(inc_q);
				end
				wtirq_pkg::MODE_DATA_RD: begin
					ptr_q <= ptr_q + wtirq_pkg::PTR_W'(inc_q);
				end
				wtirq_pkg::MODE_CNT_LO_WR: begin
					cnt_q[7:0] <= item.data_byte;
					irq_q      <= 1'b0;
				end
				wtirq_pkg::MODE_CNT_HI_WR: begin
					cnt_q[15:8] <= item.data_byte;
					irq_q       <= 1'b0;
				end
				wtirq_pkg::MODE_CNT_LO_RD,
				wtirq_pkg::MODE_CNT_HI_RD: begin
				end
				wtirq_pkg::MODE_TICK: begin
					// Count only while enabled and below the terminal value.
					if (cnt_q[15] && (cnt_q != wtirq_pkg::CNT_TOP)) begin
						cnt_q <= cnt_inc;
						if (cnt_inc == wtirq_pkg::CNT_TOP) begin
							irq_q <= 1'b1;
						end
					end
				end
			endcase
		end
	end

	// Result assembly; counter reads leave the counter unchanged, so it is read in place.
	always_comb begin
		result.irq_line        = irq_q;
		result.active_channels = {1'b0, chan_q} + 4'd1;
		unique case (mode_s1)
			wtirq_pkg::MODE_DATA_RD:   result.read_value = rd_valid_s1 ? ram_rdata : 8'd0;
			wtirq_pkg::MODE_CNT_LO_RD: result.read_value = cnt_q[7:0];
			wtirq_pkg::MODE_CNT_HI_RD: result.read_value = cnt_q[15:8];
			default:                   result.read_value = 8'd0;
		endcase
	end

endmodule

// ===== src/wtirq_checker.sv =====
// Port-level checker for the wavetable RAM port and interrupt counter, with its bind.
`include "assert_macros.svh"

module wtirq_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 start,
	input logic                 busy,
	input wtirq_pkg::in_item_t  item,
	input logic                 done,
	input wtirq_pkg::out_item_t result
);

	logic accept;
	logic cnt_write;

	assign accept    = start & ~busy;
	assign cnt_write = accept && ((item.mode == wtirq_pkg::MODE_CNT_LO_WR) ||
		(item.mode == wtirq_pkg::MODE_CNT_HI_WR));

	// Every transfer yields its result in the next cycle.
	`ASSERT_NEXT(a_result_follows, clk, arst_n, accept, done)

	// Results are never shown back to back.
	`ASSERT_NEXT(a_no_double_result, clk, arst_n, done, !done)

	// The channel count always lies between one and eight.
	`ASSERT_SAME(a_chan_range, clk, arst_n, done,
		(result.active_channels != 4'd0) &&
		!(result.active_channels[3] && (result.active_channels[2:0] != 3'd0)))

	// A counter write always leaves the interrupt cleared.
	`ASSERT_NEXT(a_cnt_write_clears_irq, clk, arst_n, cnt_write, !result.irq_line)

endmodule

bind wavetable_ram_port_and_irq_counter_core wtirq_checker u_wtirq_checker (.*);
